FILE: hdl/ejl_pkg.sv
package ejl_pkg;

  localparam int unsigned OffsetBits = 32;

  localparam logic [7:0] MarkPrefix = 8'hFF;
  localparam logic [7:0] MarkSoi    = 8'hD8;
  localparam logic [7:0] MarkEoi    = 8'hD9;
  localparam logic [7:0] FrameMask  = 8'hF0;
  localparam logic [7:0] FrameBase  = 8'hC0;
  localparam logic [7:0] MarkDht    = 8'hC4;

  localparam logic [3:0] StepIdle   = 4'd0;
  localparam logic [3:0] StepStart  = 4'd1;
  localparam logic [3:0] StepHeight = 4'd5;
  localparam logic [3:0] StepHLow   = 4'd6;
  localparam logic [3:0] StepWidth  = 4'd7;
  localparam logic [3:0] StepDone   = 4'd8;

  typedef logic [OffsetBits-1:0] pos_t;

  typedef enum logic [1:0] {
    StFound    = 2'd0,
    StNoJpeg   = 2'd1,
    StTooSmall = 2'd2,
    StTooLong  = 2'd3
  } status_e;

  typedef struct packed {
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [31:0] jpeg_length;
    logic [31:0] jpeg_offset;
    status_e     status;
  } result_t;

  localparam int unsigned ResultBits = $bits(result_t);
  localparam int unsigned TdataBits  = ((ResultBits + 7) / 8) * 8;

  function automatic logic [31:0] low_word(pos_t v);
    logic [OffsetBits+31:0] ext;
    ext = {32'd0, v};
    return ext[31:0];
  endfunction

endpackage

FILE: hdl/embedded_jpeg_locator_unit.sv
// Channel   | Direction | Payload
// s_axis    | in        | tdata[7:0] data_byte, tlast last_byte
// m_axis    | out       | tdata status, jpeg_offset, jpeg_length, image_height, image_width
//
// One byte is taken every cycle while s_axis_tready_o is high; the scan state updates in
// the cycle the byte is taken. A last byte's result is registered, then shows on m_axis.
// A two-entry output buffer holds results; s_axis_tready_o drops only while both are full.
// Reset is asynchronous and clears all scan state at once; no clearing pass is needed.
module embedded_jpeg_locator_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [7:0]                    s_axis_tdata_i,  // data_byte
  input  logic                          s_axis_tlast_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // status, jpeg_offset, jpeg_length, image_height, image_width
  output logic [ejl_pkg::TdataBits-1:0] m_axis_tdata_o
);

  logic             accept;
  logic             res_valid;
  ejl_pkg::result_t res;
  ejl_pkg::result_t out_data;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  ejl_scanner u_scanner (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (s_axis_tdata_i),
    .last_byte_i (s_axis_tlast_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ejl_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (res_valid),
    .push_data_i  (res),
    .push_ready_o (s_axis_tready_o),
    .pop_valid_o  (m_axis_tvalid_o),
    .pop_ready_i  (m_axis_tready_i),
    .pop_data_o   (out_data)
  );

  assign m_axis_tdata_o =
    {{(ejl_pkg::TdataBits - ejl_pkg::ResultBits){1'b0}}, out_data};

  a_stall_has_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with no result pending");

  a_result_from_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(accept && s_axis_tlast_i))
    else $error("result appeared without a last byte");

  a_fail_fields_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (out_data.status != ejl_pkg::StFound)) |->
      (out_data.jpeg_offset == '0 && out_data.jpeg_length == '0 &&
       out_data.image_height == '0 && out_data.image_width == '0))
    else $error("nonzero fields on a failed scan");

endmodule

FILE: hdl/ejl_scanner.sv
module ejl_scanner (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       data_byte_i,
  input  logic             last_byte_i,
  output logic             res_valid_o,
  output ejl_pkg::result_t res_o
);

  ejl_pkg::pos_t pos_q, pos_d;
  logic [7:0]    prev_byte_q, prev_byte_d;
  logic          prev_valid_q, prev_valid_d;
  logic          open_q, open_d;
  ejl_pkg::pos_t open_start_q, open_start_d;
  logic [3:0]    step_q, step_d;
  logic [31:0]   open_dim_q, open_dim_d;
  ejl_pkg::pos_t best_start_q, best_start_d;
  ejl_pkg::pos_t best_len_q, best_len_d;
  logic [31:0]   best_dim_q, best_dim_d;
  logic          ovf_q, ovf_d;

  logic          prev_ff;
  ejl_pkg::pos_t span_len;

  assign prev_ff = prev_valid_q && (prev_byte_q == ejl_pkg::MarkPrefix);

  always_comb begin
    pos_d        = pos_q;
    prev_byte_d  = prev_byte_q;
    prev_valid_d = prev_valid_q;
    open_d       = open_q;
    open_start_d = open_start_q;
    step_d       = step_q;
    open_dim_d   = open_dim_q;
    best_start_d = best_start_q;
    best_len_d   = best_len_q;
    best_dim_d   = best_dim_q;
    ovf_d        = ovf_q;
    span_len     = pos_q + ejl_pkg::pos_t'(1) - open_start_q;
    res_valid_o  = 1'b0;
    res_o        = '0;

    if (accept_i) begin
      if (ovf_q || (pos_q == '1)) begin
        ovf_d = 1'b1;
      end else begin
        if (open_q) begin
          if ((step_q >= ejl_pkg::StepStart) && (step_q < ejl_pkg::StepDone)) begin
            step_d = step_q + 4'd1;
            case (step_d)
              ejl_pkg::StepHeight: open_dim_d[31:24] = data_byte_i;
              ejl_pkg::StepHLow:   open_dim_d[23:16] = data_byte_i;
              ejl_pkg::StepWidth:  open_dim_d[15:8]  = data_byte_i;
              ejl_pkg::StepDone:   open_dim_d[7:0]   = data_byte_i;
              default: ;
            endcase
          end else if ((step_q == ejl_pkg::StepIdle) && prev_ff &&
                       ((data_byte_i & ejl_pkg::FrameMask) == ejl_pkg::FrameBase) &&
                       (data_byte_i != ejl_pkg::MarkDht)) begin
            step_d     = ejl_pkg::StepStart;
            open_dim_d = '0;
          end
          if (prev_ff && (data_byte_i == ejl_pkg::MarkEoi)) begin
            if (span_len > best_len_q) begin
              best_len_d   = span_len;
              best_start_d = open_start_q;
              best_dim_d   = (step_d == ejl_pkg::StepDone) ? open_dim_d : '0;
            end
            open_d     = 1'b0;
            step_d     = ejl_pkg::StepIdle;
            open_dim_d = '0;
          end
        end else if (prev_ff && (data_byte_i == ejl_pkg::MarkSoi)) begin
          open_d       = 1'b1;
          open_start_d = pos_q - ejl_pkg::pos_t'(1);
          step_d       = ejl_pkg::StepIdle;
          open_dim_d   = '0;
        end
        pos_d = pos_q + ejl_pkg::pos_t'(1);
      end
      prev_byte_d  = data_byte_i;
      prev_valid_d = 1'b1;

      if (last_byte_i) begin
        res_valid_o = 1'b1;
        if (ovf_d) begin
          res_o.status = ejl_pkg::StTooLong;
        end else if (pos_d < ejl_pkg::pos_t'(4)) begin
          res_o.status = ejl_pkg::StTooSmall;
        end else if (best_len_d == '0) begin
          res_o.status = ejl_pkg::StNoJpeg;
        end else begin
          res_o.status       = ejl_pkg::StFound;
          res_o.jpeg_offset  = ejl_pkg::low_word(best_start_d);
          res_o.jpeg_length  = ejl_pkg::low_word(best_len_d);
          res_o.image_height = best_dim_d[31:16];
          res_o.image_width  = best_dim_d[15:0];
        end
        pos_d        = '0;
        prev_byte_d  = '0;
        prev_valid_d = 1'b0;
        open_d       = 1'b0;
        open_start_d = '0;
        step_d       = ejl_pkg::StepIdle;
        open_dim_d   = '0;
        best_start_d = '0;
        best_len_d   = '0;
        best_dim_d   = '0;
        ovf_d        = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      prev_byte_q  <= '0;
      prev_valid_q <= 1'b0;
      open_q       <= 1'b0;
      open_start_q <= '0;
      step_q       <= ejl_pkg::StepIdle;
      open_dim_q   <= '0;
      best_start_q <= '0;
      best_len_q   <= '0;
      best_dim_q   <= '0;
      ovf_q        <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      prev_byte_q  <= prev_byte_d;
      prev_valid_q <= prev_valid_d;
      open_q       <= open_d;
      open_start_q <= open_start_d;
      step_q       <= step_d;
      open_dim_q   <= open_dim_d;
      best_start_q <= best_start_d;
      best_len_q   <= best_len_d;
      best_dim_q   <= best_dim_d;
      ovf_q        <= ovf_d;
    end
  end

endmodule

FILE: hdl/ejl_out_buf.sv
module ejl_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  input  ejl_pkg::result_t push_data_i,
  output logic             push_ready_o,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output ejl_pkg::result_t pop_data_o
);

  logic             main_valid_q, main_valid_d;
  ejl_pkg::result_t main_data_q, main_data_d;
  logic             skid_valid_q, skid_valid_d;
  ejl_pkg::result_t skid_data_q, skid_data_d;
  logic             push;
  logic             pop;

  assign push_ready_o = !skid_valid_q;
  assign pop_valid_o  = main_valid_q;
  assign pop_data_o   = main_data_q;
  assign push         = push_valid_i && !skid_valid_q;
  assign pop          = main_valid_q && pop_ready_i;

  always_comb begin
    main_valid_d = main_valid_q;
    main_data_d  = main_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      if (pop) begin
        main_data_d  = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (!main_valid_q || pop) begin
      main_valid_d = push;
      main_data_d  = push_data_i;
    end else if (push) begin
      skid_valid_d = 1'b1;
      skid_data_d  = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_data_q <= main_data_d;
    skid_data_q <= skid_data_d;
  end

endmodule

FILE: verif/tb_embedded_jpeg_locator_unit.sv
module tb_embedded_jpeg_locator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchLimit = 4000;
  localparam int unsigned HoldCycles = 400;

  logic                          clk_i  = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_valid = 1'b0;
  logic                          s_ready;
  logic [7:0]                    s_data  = 8'h00;
  logic                          s_last  = 1'b0;
  logic                          m_valid;
  logic                          m_ready = 1'b0;
  logic [ejl_pkg::TdataBits-1:0] m_data;

  // scan state of the predictor
  ejl_pkg::pos_t pos_cnt;
  logic [7:0]    prev_b;
  logic          prev_ok;
  logic          span_open;
  ejl_pkg::pos_t span_start;
  logic [3:0]    cap_step;
  logic [31:0]   span_dims;
  ejl_pkg::pos_t best_start;
  ejl_pkg::pos_t best_len;
  logic [31:0]   best_dims;
  logic          ovf;

  ejl_pkg::result_t expected_reports[$];
  logic [7:0]       file_bytes[$];
  int               err_count    = 0;
  int               quiet_cycles = 0;
  bit               tx_quiet     = 1'b0;
  bit               rx_quiet     = 1'b0;
  int               hold_arm     = 0;
  int               hold_done    = 0;
  int               hold_left    = 0;
  int               idle_left    = 0;

  embedded_jpeg_locator_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void clear_scan();
    pos_cnt    = '0;
    prev_b     = 8'h00;
    prev_ok    = 1'b0;
    span_open  = 1'b0;
    span_start = '0;
    cap_step   = ejl_pkg::StepIdle;
    span_dims  = 32'd0;
    best_start = '0;
    best_len   = '0;
    best_dims  = 32'd0;
    ovf        = 1'b0;
  endfunction

  function automatic void scan_predict(logic [7:0] b, logic last);
    logic             prev_ff;
    ejl_pkg::pos_t    len;
    ejl_pkg::result_t rep;
    prev_ff = prev_ok && (prev_b == ejl_pkg::MarkPrefix);
    if (ovf || pos_cnt == '1) begin
      ovf = 1'b1;
    end else begin
      if (span_open) begin
        if (cap_step >= ejl_pkg::StepStart && cap_step < ejl_pkg::StepDone) begin
          cap_step = cap_step + 4'd1;
          case (cap_step)
            ejl_pkg::StepHeight: span_dims[31:24] = b;
            ejl_pkg::StepHLow:   span_dims[23:16] = b;
            ejl_pkg::StepWidth:  span_dims[15:8]  = b;
            ejl_pkg::StepDone:   span_dims[7:0]   = b;
            default: ;
          endcase
        end else if (cap_step == ejl_pkg::StepIdle && prev_ff &&
                     (b & ejl_pkg::FrameMask) == ejl_pkg::FrameBase &&
                     b != ejl_pkg::MarkDht) begin
          cap_step  = ejl_pkg::StepStart;
          span_dims = 32'd0;
        end
        if (prev_ff && b == ejl_pkg::MarkEoi) begin
          len = pos_cnt + ejl_pkg::pos_t'(1) - span_start;
          if (len > best_len) begin
            best_len   = len;
            best_start = span_start;
            best_dims  = (cap_step == ejl_pkg::StepDone) ? span_dims : 32'd0;
          end
          span_open = 1'b0;
          cap_step  = ejl_pkg::StepIdle;
          span_dims = 32'd0;
        end
      end else if (prev_ff && b == ejl_pkg::MarkSoi) begin
        span_open  = 1'b1;
        span_start = pos_cnt - ejl_pkg::pos_t'(1);
        cap_step   = ejl_pkg::StepIdle;
        span_dims  = 32'd0;
      end
      pos_cnt = pos_cnt + ejl_pkg::pos_t'(1);
    end
    prev_b  = b;
    prev_ok = 1'b1;
    if (last) begin
      rep = '0;
      if (ovf) begin
        rep.status = ejl_pkg::StTooLong;
      end else if (pos_cnt < ejl_pkg::pos_t'(4)) begin
        rep.status = ejl_pkg::StTooSmall;
      end else if (best_len == '0) begin
        rep.status = ejl_pkg::StNoJpeg;
      end else begin
        rep.status       = ejl_pkg::StFound;
        rep.jpeg_offset  = ejl_pkg::low_word(best_start);
        rep.jpeg_length  = ejl_pkg::low_word(best_len);
        rep.image_height = best_dims[31:16];
        rep.image_width  = best_dims[15:0];
      end
      expected_reports = {expected_reports, rep};
      clear_scan();
    end
  endfunction

  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return ejl_pkg::MarkPrefix;
      1: return ejl_pkg::MarkSoi;
      2: return ejl_pkg::MarkEoi;
      3: return ejl_pkg::FrameBase | 8'($urandom_range(0, 15));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void build_file();
    logic [7:0] span_q[$];
    int         nseg;
    file_bytes.delete();
    if ($urandom_range(0, 15) == 0) begin
      repeat ($urandom_range(1, 4)) file_bytes = {file_bytes, pick_byte()};
      return;
    end
    nseg = $urandom_range(1, 4);
    repeat (nseg) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(0, 6)) file_bytes = {file_bytes, pick_byte()};
      end else begin
        span_q.delete();
        span_q = {span_q, ejl_pkg::MarkPrefix, ejl_pkg::MarkSoi};
        if ($urandom_range(0, 5) == 0) begin
          span_q = {span_q, ejl_pkg::MarkPrefix, ejl_pkg::MarkSoi};
        end
        if ($urandom_range(0, 3) != 0) begin
          span_q = {span_q, ejl_pkg::MarkPrefix,
                    ejl_pkg::FrameBase | 8'($urandom_range(0, 15))};
          repeat ($urandom_range(0, 10)) span_q = {span_q, pick_byte()};
        end
        repeat ($urandom_range(0, 4)) span_q = {span_q, pick_byte()};
        if ($urandom_range(0, 7) != 0) begin
          span_q = {span_q, ejl_pkg::MarkPrefix, ejl_pkg::MarkEoi};
        end
        file_bytes = {file_bytes, span_q};
        // repeat the span to get a tie on length
        if ($urandom_range(0, 3) == 0) file_bytes = {file_bytes, span_q};
      end
    end
    if (file_bytes.size() == 0) file_bytes = {file_bytes, pick_byte()};
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    err_count++;
  endtask

  task automatic check_report(logic [ejl_pkg::TdataBits-1:0] tdata);
    ejl_pkg::result_t got;
    ejl_pkg::result_t want;
    got = tdata[ejl_pkg::ResultBits-1:0];
    if (expected_reports.size() == 0) begin
      report_mismatch("result with no request pending");
      return;
    end
    want = expected_reports.pop_front();
    if (got.status !== want.status)
      report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
    if (got.jpeg_offset !== want.jpeg_offset)
      report_mismatch($sformatf("jpeg_offset got %0h want %0h",
                                got.jpeg_offset, want.jpeg_offset));
    if (got.jpeg_length !== want.jpeg_length)
      report_mismatch($sformatf("jpeg_length got %0h want %0h",
                                got.jpeg_length, want.jpeg_length));
    if (got.image_height !== want.image_height)
      report_mismatch($sformatf("image_height got %0h want %0h",
                                got.image_height, want.image_height));
    if (got.image_width !== want.image_width)
      report_mismatch($sformatf("image_width got %0h want %0h",
                                got.image_width, want.image_width));
    if (tdata[ejl_pkg::TdataBits-1:ejl_pkg::ResultBits] !== '0)
      report_mismatch($sformatf("tdata padding got %0h",
                                tdata[ejl_pkg::TdataBits-1:ejl_pkg::ResultBits]));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_valid && m_ready) check_report(m_data);
      if (hold_arm != hold_done) begin
        hold_done <= hold_arm;
        hold_left <= HoldCycles;
        m_ready   <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_ready   <= 1'b0;
      end else if (idle_left > 0) begin
        idle_left <= idle_left - 1;
        m_ready   <= 1'b0;
      end else begin
        m_ready <= 1'b1;
        if (!rx_quiet && $urandom_range(0, 4) == 0) idle_left <= pick_gap(1'b0);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchLimit) begin
        $display("timeout: no request accepted for %0d cycles", quiet_cycles);
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    gap = pick_gap(tx_quiet);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    s_last  <= last;
    do @(posedge clk_i); while (!s_ready);
    scan_predict(b, last);
  endtask

  task automatic send_file();
    foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
  endtask

  task automatic test_short_files();
    file_bytes = '{8'h00};
    send_file();
    file_bytes = '{ejl_pkg::MarkPrefix, ejl_pkg::MarkSoi};
    send_file();
    file_bytes = '{ejl_pkg::MarkPrefix, ejl_pkg::MarkPrefix, ejl_pkg::MarkPrefix};
    send_file();
    file_bytes = '{ejl_pkg::MarkPrefix, ejl_pkg::MarkSoi, ejl_pkg::MarkPrefix,
                   ejl_pkg::MarkEoi};
    send_file();
    file_bytes = '{ejl_pkg::MarkPrefix, ejl_pkg::MarkSoi, 8'h00, ejl_pkg::MarkPrefix};
    send_file();
  endtask

  task automatic test_frame_capture();
    file_bytes = '{8'h00, ejl_pkg::MarkPrefix, ejl_pkg::MarkSoi, ejl_pkg::MarkPrefix,
                   ejl_pkg::FrameBase, 8'h12, 8'h34, 8'h56, 8'hFF, 8'hFF, 8'h00, 8'h01,
                   ejl_pkg::MarkPrefix, ejl_pkg::MarkEoi, 8'h00};
    send_file();
  endtask

  task automatic test_random_files(int budget);
    int sent;
    sent = 0;
    while (sent < budget) begin
      build_file();
      send_file();
      sent += file_bytes.size();
    end
  endtask

  task automatic test_backpressure();
    hold_arm <= hold_arm + 1;
    tx_quiet = 1'b1;
    repeat (12) begin
      file_bytes = '{ejl_pkg::MarkPrefix, ejl_pkg::MarkSoi, pick_byte(),
                     ejl_pkg::MarkPrefix, ejl_pkg::MarkEoi};
      send_file();
    end
    tx_quiet = 1'b0;
  endtask

  task automatic test_no_idle();
    tx_quiet = 1'b1;
    rx_quiet <= 1'b1;
    test_random_files(150);
    tx_quiet = 1'b0;
    rx_quiet <= 1'b0;
  endtask

  initial begin
    clear_scan();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_short_files();
    test_frame_capture();
    test_random_files(1200);
    test_backpressure();
    test_no_idle();
    s_valid <= 1'b0;
    wait (expected_reports.size() == 0);
    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: embedded_jpeg_locator_unit.f
hdl/ejl_pkg.sv
hdl/ejl_scanner.sv
hdl/ejl_out_buf.sv
hdl/embedded_jpeg_locator_unit.sv
verif/tb_embedded_jpeg_locator_unit.sv
